[src/sprite_line_fetch_generator_core_macros.svh]
// Assertion helpers used by the sprite line fetch controller.
`ifndef SPRITE_LINE_FETCH_GENERATOR_CORE_MACROS_SVH
`define SPRITE_LINE_FETCH_GENERATOR_CORE_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define SLFG_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Expression must never be true outside reset.
`define SLFG_ASSERT_NEVER(label, clk, rst_n, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

[src/slfg_pkg.sv]
package slfg_pkg;

  localparam int unsigned ScreenWidthDefault = 240;

  localparam int unsigned AttrW   = 16;
  localparam int unsigned LineW   = 8;
  localparam int unsigned BaseW   = 17;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgW    = 17;
  localparam int unsigned ColW    = 11;
  localparam int unsigned DimW    = 7;
  localparam int unsigned PosW    = 6;
  localparam int unsigned TileW   = 11;

  localparam logic [BaseW-1:0] TileBaseReset = 17'h10000;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_CURRENT_LINE     = 2'd0,
    CFG_MAPPING_LINEAR   = 2'd1,
    CFG_TILE_REGION_BASE = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [DimW-1:0] w;
    logic [DimW-1:0] h;
  } obj_dims_t;

  typedef struct packed {
    logic load;
    logic step;
  } slfg_cmd_t;

  typedef struct packed {
    logic hit;
    logic last;
  } slfg_status_t;

  function automatic obj_dims_t obj_dims(input logic [1:0] shape, input logic [1:0] size);
    obj_dims_t d;
    d = '0;
    unique case ({shape, size})
      4'b0000: d = '{w: 7'd8,  h: 7'd8};
      4'b0001: d = '{w: 7'd16, h: 7'd16};
      4'b0010: d = '{w: 7'd32, h: 7'd32};
      4'b0011: d = '{w: 7'd64, h: 7'd64};
      4'b0100: d = '{w: 7'd16, h: 7'd8};
      4'b0101: d = '{w: 7'd32, h: 7'd8};
      4'b0110: d = '{w: 7'd32, h: 7'd16};
      4'b0111: d = '{w: 7'd64, h: 7'd32};
      4'b1000: d = '{w: 7'd8,  h: 7'd16};
      4'b1001: d = '{w: 7'd8,  h: 7'd32};
      4'b1010: d = '{w: 7'd16, h: 7'd32};
      4'b1011: d = '{w: 7'd32, h: 7'd64};
      default: d = '0;
    endcase
    return d;
  endfunction

endpackage

[src/slfg_if.sv]
interface slfg_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] attr_word0;
  logic [15:0] attr_word1;
  logic [15:0] attr_word2;

  modport source (output valid, output attr_word0, output attr_word1, output attr_word2,
                  input ready);
  modport sink   (input valid, input attr_word0, input attr_word1, input attr_word2,
                  output ready);
endinterface

interface slfg_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  screen_column;
  logic [10:0] tile_index;
  logic [2:0]  pixel_col;
  logic [2:0]  pixel_row;
  logic [4:0]  palette_bank;
  logic        full_colour;
  logic [1:0]  layer_priority;
  logic [16:0] fetch_base;
  logic        run_end;

  modport source (output valid, output screen_column, output tile_index, output pixel_col,
                  output pixel_row, output palette_bank, output full_colour,
                  output layer_priority, output fetch_base, output run_end, input ready);
  modport sink   (input valid, input screen_column, input tile_index, input pixel_col,
                  input pixel_row, input palette_bank, input full_colour,
                  input layer_priority, input fetch_base, input run_end, output ready);
endinterface

[src/sprite_line_fetch_generator_core.sv]
// Sprite line fetch generator.
// in_ch carries one sprite's three attribute words per transfer; out_ch
// carries one tile-pixel fetch request per transfer, in ascending screen
// column order, with run_end set on the last request of the sprite.
// The cfg port writes current_line (0), mapping_linear (1) or
// tile_region_base (2), one register per write; write it only while the block is idle.
// Latency: the first request is valid in the cycle after the input transfer.
// Throughput: one request per cycle while out_ch is ready; the step counter
// of the datapath paces the run. A sprite that is off the line, off screen
// or of prohibited shape yields nothing: it is loaded, the run state sees no
// hit and returns to idle, which frees the input.
// in_ch.ready is high only between sprites.
// When out_ch stalls, the current request holds and the run waits.
// Reset: returns to idle, current_line 0, mapping_linear 0, base 0x10000.
module sprite_line_fetch_generator_core #(
  parameter int unsigned SCREEN_WIDTH = slfg_pkg::ScreenWidthDefault
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  slfg_in_if.sink                      in_ch,
  slfg_out_if.source                   out_ch,
  input  logic                         cfg_we_i,
  input  logic [slfg_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [slfg_pkg::CfgW-1:0]    cfg_wdata_i
);
  import slfg_pkg::*;

  logic [LineW-1:0] current_line_q;
  logic             mapping_linear_q;
  logic [BaseW-1:0] region_base_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      current_line_q   <= '0;
      mapping_linear_q <= 1'b0;
      region_base_q    <= TileBaseReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_CURRENT_LINE:     current_line_q   <= cfg_wdata_i[LineW-1:0];
        CFG_MAPPING_LINEAR:   mapping_linear_q <= cfg_wdata_i[0];
        CFG_TILE_REGION_BASE: region_base_q    <= cfg_wdata_i[BaseW-1:0];
        default: ;
      endcase
    end
  end

  slfg_cmd_t    cmd;
  slfg_status_t status;

  slfg_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_ch.valid),
    .in_ready_o  (in_ch.ready),
    .out_valid_o (out_ch.valid),
    .out_ready_i (out_ch.ready),
    .cmd_o       (cmd),
    .status_i    (status)
  );

  slfg_datapath #(
    .SCREEN_WIDTH (SCREEN_WIDTH)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .status_o         (status),
    .current_line_i   (current_line_q),
    .mapping_linear_i (mapping_linear_q),
    .attr_word0_i     (in_ch.attr_word0),
    .attr_word1_i     (in_ch.attr_word1),
    .attr_word2_i     (in_ch.attr_word2),
    .screen_column_o  (out_ch.screen_column),
    .tile_index_o     (out_ch.tile_index),
    .pixel_col_o      (out_ch.pixel_col),
    .pixel_row_o      (out_ch.pixel_row),
    .palette_bank_o   (out_ch.palette_bank),
    .full_colour_o    (out_ch.full_colour),
    .layer_priority_o (out_ch.layer_priority)
  );

  assign out_ch.fetch_base = region_base_q;
  assign out_ch.run_end    = status.last;

endmodule

[src/slfg_datapath.sv]
module slfg_datapath #(
  parameter int unsigned SCREEN_WIDTH = slfg_pkg::ScreenWidthDefault
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  slfg_pkg::slfg_cmd_t         cmd_i,
  output slfg_pkg::slfg_status_t      status_o,
  input  logic [slfg_pkg::LineW-1:0]  current_line_i,
  input  logic                        mapping_linear_i,
  input  logic [15:0]                 attr_word0_i,
  input  logic [15:0]                 attr_word1_i,
  input  logic [15:0]                 attr_word2_i,
  output logic [7:0]                  screen_column_o,
  output logic [slfg_pkg::TileW-1:0]  tile_index_o,
  output logic [2:0]                  pixel_col_o,
  output logic [2:0]                  pixel_row_o,
  output logic [4:0]                  palette_bank_o,
  output logic                        full_colour_o,
  output logic [1:0]                  layer_priority_o
);
  import slfg_pkg::*;

  localparam logic signed [ColW-1:0] SwLast = ColW'(SCREEN_WIDTH - 1);
  localparam logic signed [ColW-1:0] SwCol  = ColW'(SCREEN_WIDTH);

  // decode of the incoming attribute words
  obj_dims_t               dims;
  logic                    affine, full, vflip;
  logic [LineW-1:0]        line_raw, line_f;
  logic                    line_ok;
  logic [2:0]              trow;
  logic [TileW-1:0]        num_base, num_adv;
  logic signed [ColW-1:0]  xpos, start, first_col;
  logic                    start_ok, col_ok;

  always_comb begin
    dims      = obj_dims(attr_word0_i[15:14], attr_word1_i[15:14]);
    affine    = attr_word0_i[8];
    full      = attr_word0_i[13];
    vflip     = !affine && attr_word1_i[13];
    line_raw  = current_line_i - attr_word0_i[7:0];
    line_ok   = line_raw < {1'b0, dims.h};
    line_f    = vflip ? ({1'b0, dims.h} - 8'd1 - line_raw) : line_raw;
    trow      = line_f[5:3];
    num_base  = full ? {2'b00, attr_word2_i[9:1]} : {1'b0, attr_word2_i[9:0]};
    if (mapping_linear_i) begin
      num_adv = TileW'(trow) * TileW'(dims.w[6:3]);
    end else if (full) begin
      num_adv = TileW'({trow, 4'b0000});
    end else begin
      num_adv = TileW'({trow, 5'b00000});
    end
    xpos      = ColW'($signed(attr_word1_i[8:0]));
    start     = xpos[ColW-1] ? -xpos : '0;
    first_col = xpos[ColW-1] ? '0 : xpos;
    start_ok  = start < $signed({4'b0000, dims.w});
    col_ok    = first_col < SwCol;
  end

  logic                    hit_q;
  logic [DimW-1:0]         width_q;
  logic [TileW-1:0]        number_q;
  logic [2:0]              trowy_q;
  logic [4:0]              bank_q;
  logic                    full_q;
  logic [1:0]              prio_q;
  logic [PosW-1:0]         pos_q;
  logic signed [ColW-1:0]  col_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q <= 1'b0;
    end else if (cmd_i.load) begin
      hit_q <= (dims.w != '0) && line_ok && start_ok && col_ok;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      width_q  <= dims.w;
      number_q <= num_base + num_adv;
      trowy_q  <= line_f[2:0];
      bank_q   <= full ? 5'd16 : {1'b1, attr_word2_i[15:12]};
      full_q   <= full;
      prio_q   <= attr_word2_i[11:10];
      pos_q    <= start[PosW-1:0];
      col_q    <= first_col;
    end else if (cmd_i.step) begin
      pos_q    <= pos_q + PosW'(1);
      col_q    <= col_q + ColW'(1);
    end
  end

  assign status_o.hit  = hit_q;
  assign status_o.last = ({1'b0, pos_q} == (width_q - DimW'(1))) || (col_q >= SwLast);

  assign screen_column_o  = col_q[7:0];
  assign tile_index_o     = number_q + TileW'(pos_q[5:3]);
  assign pixel_col_o      = pos_q[2:0];
  assign pixel_row_o      = trowy_q;
  assign palette_bank_o   = bank_q;
  assign full_colour_o    = full_q;
  assign layer_priority_o = prio_q;

endmodule

[src/slfg_ctrl.sv]
`include "sprite_line_fetch_generator_core_macros.svh"

module slfg_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output slfg_pkg::slfg_cmd_t    cmd_o,
  input  slfg_pkg::slfg_status_t status_i
);
  import slfg_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } state_e;

  state_e state_q, state_d;
  logic   in_xfer, out_xfer;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = (state_q == ST_RUN) && status_i.hit;
  assign in_xfer     = in_valid_i && in_ready_o;
  assign out_xfer    = out_valid_o && out_ready_i;

  always_comb begin
    state_d    = state_q;
    cmd_o.load = 1'b0;
    cmd_o.step = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          cmd_o.load = 1'b1;
          state_d    = ST_RUN;
        end
      end
      ST_RUN: begin
        if (!status_i.hit) begin
          state_d = ST_IDLE;
        end else if (out_xfer) begin
          if (status_i.last) begin
            state_d = ST_IDLE;
          end else begin
            cmd_o.step = 1'b1;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  `SLFG_ASSERT_NEVER(a_no_overlap, clk_i, rst_ni, in_ready_o && out_valid_o, "input taken during run")
  `SLFG_ASSERT(a_last_frees, clk_i, rst_ni, out_xfer && status_i.last |=> in_ready_o, "no idle after last transfer")
  `SLFG_ASSERT(a_load_runs, clk_i, rst_ni, in_xfer |=> !in_ready_o, "load did not start a run")
  `SLFG_ASSERT_NEVER(a_cmd_excl, clk_i, rst_ni, cmd_o.load && cmd_o.step, "load and step together")

endmodule

[verif/tb.sv]
`timescale 1ns / 1ps

module tb;
  import slfg_pkg::*;

  localparam int ScreenW = 240;
  localparam int StallLimit = 2000;
  localparam int HoldCycles = 300;
  localparam int DrainCycles = 6;

  localparam logic [1:0] ShapeSquare = 2'd0;
  localparam logic [1:0] ShapeWide = 2'd1;
  localparam logic [1:0] ShapeTall = 2'd2;
  localparam logic [1:0] ShapeProhibited = 2'd3;
  localparam logic [CfgIdxW-1:0] CfgIdxUnused = 2'd3;

  typedef struct packed {
    logic [7:0]  column;
    logic [10:0] tile;
    logic [2:0]  px;
    logic [2:0]  py;
    logic [4:0]  bank;
    logic        full;
    logic [1:0]  prio;
    logic [16:0] base;
    logic        last;
  } fetch_req_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_we;
  logic [CfgIdxW-1:0] cfg_idx;
  logic [CfgW-1:0] cfg_wdata;

  slfg_in_if sprite_ch ();
  slfg_out_if fetch_ch ();

  sprite_line_fetch_generator_core #(
    .SCREEN_WIDTH(ScreenW)
  ) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_ch      (sprite_ch),
    .out_ch     (fetch_ch),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_wdata_i(cfg_wdata)
  );

  // register shadow
  logic [7:0] line_reg = 8'd0;
  logic linear_map = 1'b0;
  logic [16:0] base_shadow = TileBaseReset;

  fetch_req_t pending_fetches[$];
  int errors = 0;
  int sprites_sent = 0;
  int fetches_checked = 0;
  int settings_used = 1;
  bit steady = 1'b0;
  bit hold_request = 1'b0;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic void sprite_dims(input logic [1:0] shape, input logic [1:0] sz,
                                      output int wd, output int ht);
    wd = 0;
    ht = 0;
    case (shape)
      ShapeSquare: begin
        wd = 8 << sz;
        ht = wd;
      end
      ShapeWide: begin
        case (sz)
          2'd0: begin wd = 16; ht = 8; end
          2'd1: begin wd = 32; ht = 8; end
          2'd2: begin wd = 32; ht = 16; end
          default: begin wd = 64; ht = 32; end
        endcase
      end
      ShapeTall: begin
        case (sz)
          2'd0: begin wd = 8; ht = 16; end
          2'd1: begin wd = 8; ht = 32; end
          2'd2: begin wd = 16; ht = 32; end
          default: begin wd = 32; ht = 64; end
        endcase
      end
      default: ;
    endcase
  endfunction

  function automatic void queue_fetches(input logic [15:0] w0, w1, w2);
    int wd, ht, x, first, trow, number, n;
    logic [7:0] row;
    logic full;
    fetch_req_t req;
    sprite_dims(w0[15:14], w1[15:14], wd, ht);
    if (wd == 0) return;
    x = w1[8] ? int'(w1[8:0]) - 512 : int'(w1[8:0]);
    row = line_reg - w0[7:0];
    if (row >= ht) return;
    if (!w0[8] && w1[13]) row = 8'(ht - 1 - int'(row));
    full = w0[13];
    trow = row >> 3;
    number = full ? (w2[9:0] >> 1) : w2[9:0];
    if (linear_map) number += trow * (wd >> 3);
    else number += full ? (trow << 4) : (trow << 5);
    first = x < 0 ? -x : 0;
    n = 0;
    for (int pos = first; pos < wd && x + pos < ScreenW; pos++) begin
      req.column = 8'(x + pos);
      req.tile = 11'(number + (pos >> 3));
      req.px = 3'(pos);
      req.py = row[2:0];
      req.bank = full ? 5'd16 : 5'd16 + w2[15:12];
      req.full = full;
      req.prio = w2[11:10];
      req.base = base_shadow;
      req.last = 1'b0;
      pending_fetches.push_back(req);
      n++;
    end
    if (n > 0) pending_fetches[pending_fetches.size() - 1].last = 1'b1;
  endfunction

  // mostly sprites that hit the current line, some raw noise
  function automatic void random_sprite(output logic [15:0] w0, w1, w2);
    int wd, ht, x;
    logic [1:0] shape, sz;
    w0 = 16'($urandom);
    w1 = 16'($urandom);
    w2 = 16'($urandom);
    if ($urandom_range(99) < 25) return;
    shape = 2'($urandom_range(0, 2));
    sz = 2'($urandom);
    sprite_dims(shape, sz, wd, ht);
    x = int'($urandom_range(0, ScreenW + 63)) - 64;
    w0[15:14] = shape;
    w0[7:0] = line_reg - 8'($urandom_range(0, ht - 1));
    w1[15:14] = sz;
    w1[8:0] = x[8:0];
  endfunction

  function automatic void check_field(input string name, input logic [16:0] want, got);
    if (got !== want) begin
      $display("%0t mismatch %s: expected %0d, actual %0d", $time, name, want, got);
      errors++;
    end
  endfunction

  task automatic send_sprite(input logic [15:0] w0, w1, w2);
    while (!steady && $urandom_range(99) < 24) begin
      sprite_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    sprite_ch.valid <= 1'b1;
    sprite_ch.attr_word0 <= w0;
    sprite_ch.attr_word1 <= w1;
    sprite_ch.attr_word2 <= w2;
    do @(posedge clk_i); while (!sprite_ch.ready);
    queue_fetches(w0, w1, w2);
    sprites_sent++;
  endtask

  task automatic send_attrs(input logic [1:0] shape, sz, input int y, x,
                            input bit vflip, affine, full,
                            input int tile, prio, pal);
    logic [15:0] w0, w1, w2;
    w0 = 16'($urandom);
    w1 = 16'($urandom);
    w0[15:14] = shape;
    w0[13] = full;
    w0[8] = affine;
    w0[7:0] = 8'(y);
    w1[15:14] = sz;
    w1[13] = vflip;
    w1[8:0] = x[8:0];
    w2 = {4'(pal), 2'(prio), 10'(tile)};
    send_sprite(w0, w1, w2);
  endtask

  task automatic drain();
    sprite_ch.valid <= 1'b0;
    while (pending_fetches.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic program_regs(input logic [7:0] line, input logic linear,
                              input logic [16:0] base, input bit poke_unused = 1'b0);
    if (poke_unused) begin
      cfg_we <= 1'b1;
      cfg_idx <= CfgIdxUnused;
      cfg_wdata <= CfgW'($urandom);
      @(posedge clk_i);
    end
    cfg_we <= 1'b1;
    cfg_idx <= CFG_CURRENT_LINE;
    cfg_wdata <= CfgW'(line);
    @(posedge clk_i);
    cfg_idx <= CFG_MAPPING_LINEAR;
    cfg_wdata <= CfgW'(linear);
    @(posedge clk_i);
    cfg_idx <= CFG_TILE_REGION_BASE;
    cfg_wdata <= base;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    line_reg = line;
    linear_map = linear;
    base_shadow = base;
    settings_used++;
    @(posedge clk_i);
  endtask

  task automatic test_reset_values();
    send_attrs(ShapeSquare, 2'd0, 0, 0, 0, 0, 0, 0, 0, 0);
    send_attrs(ShapeTall, 2'd1, 250, 100, 0, 0, 0, 513, 2, 9);
  endtask

  task automatic test_shapes();
    int wd, ht;
    drain();
    program_regs(8'd100, 1'b0, 17'h10000);
    for (int s = 0; s < 3; s++) begin
      for (int z = 0; z < 4; z++) begin
        sprite_dims(2'(s), 2'(z), wd, ht);
        send_attrs(2'(s), 2'(z), 100 - int'($urandom_range(0, ht - 1)), 16 * (4 * s + z),
                   $urandom_range(0, 1), $urandom_range(0, 1), $urandom_range(0, 1),
                   $urandom_range(0, 1023), $urandom_range(0, 3), $urandom_range(0, 15));
      end
    end
    send_attrs(ShapeProhibited, 2'd2, 100, 10, 0, 0, 0, 7, 1, 3);
  endtask

  task automatic test_attributes();
    drain();
    program_regs(8'd227, 1'b1, 17'h1FFFF, 1'b1);
    send_attrs(ShapeSquare, 2'd2, 224, 30, 1, 0, 0, 100, 1, 5);
    send_attrs(ShapeWide, 2'd3, 200, 60, 1, 1, 0, 200, 2, 6);
    send_attrs(ShapeTall, 2'd3, 167, 100, 0, 0, 1, 1023, 0, 12);
    send_attrs(ShapeSquare, 2'd3, 164, -5, 0, 0, 0, 1023, 3, 15);
    send_attrs(ShapeSquare, 2'd3, 200, -64, 0, 0, 0, 5, 0, 0);
    send_attrs(ShapeWide, 2'd0, 227, 232, 0, 0, 0, 40, 1, 1);
    send_attrs(ShapeSquare, 2'd0, 220, 239, 0, 0, 0, 41, 2, 2);
    send_attrs(ShapeSquare, 2'd0, 220, 240, 0, 0, 0, 42, 3, 3);
    send_attrs(ShapeSquare, 2'd0, 228, 50, 0, 0, 0, 43, 0, 4);
    drain();
    program_regs(8'd0, 1'b0, 17'h0);
    send_attrs(ShapeTall, 2'd3, 200, -20, 1, 0, 1, 777, 1, 8);
    send_attrs(ShapeSquare, 2'd1, 0, 120, 0, 0, 1, 1023, 3, 15);
  endtask

  task automatic test_random(input logic [7:0] line, input logic linear,
                             input logic [16:0] base, input int count);
    logic [15:0] w0, w1, w2;
    drain();
    program_regs(line, linear, base);
    repeat (count) begin
      random_sprite(w0, w1, w2);
      send_sprite(w0, w1, w2);
    end
  endtask

  // sink stalls for a long time while large square sprites keep coming
  task automatic test_output_hold();
    logic [15:0] w0, w1, w2;
    drain();
    program_regs(8'($urandom_range(0, 227)), 1'($urandom), 17'($urandom));
    hold_request = 1'b1;
    repeat (6) begin
      w0 = 16'($urandom);
      w1 = 16'($urandom);
      w2 = 16'($urandom);
      w0[15:14] = ShapeSquare;
      w0[7:0] = line_reg - 8'($urandom_range(0, 63));
      w1[15:14] = 2'd3;
      w1[8:0] = 9'($urandom_range(0, ScreenW - 64));
      send_sprite(w0, w1, w2);
    end
  endtask

  initial begin
    int hold_left;
    hold_left = 0;
    fetch_ch.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_left > 0) begin
        hold_left--;
        fetch_ch.ready <= 1'b0;
      end else if (hold_request) begin
        hold_request = 1'b0;
        hold_left = HoldCycles - 1;
        fetch_ch.ready <= 1'b0;
      end else begin
        fetch_ch.ready <= steady || $urandom_range(99) >= 24;
      end
    end
  end

  initial begin
    fetch_req_t want, got;
    int quiet_cycles;
    quiet_cycles = 0;
    forever begin
      @(posedge clk_i);
      if (!rst_ni) continue;
      quiet_cycles++;
      if ((sprite_ch.valid && sprite_ch.ready) || cfg_we) quiet_cycles = 0;
      if (fetch_ch.valid && fetch_ch.ready) begin
        quiet_cycles = 0;
        got = {fetch_ch.screen_column, fetch_ch.tile_index, fetch_ch.pixel_col,
               fetch_ch.pixel_row, fetch_ch.palette_bank, fetch_ch.full_colour,
               fetch_ch.layer_priority, fetch_ch.fetch_base, fetch_ch.run_end};
        if (pending_fetches.size() == 0) begin
          $display("%0t unexpected transfer: expected none, actual column %0d tile %0d",
                   $time, got.column, got.tile);
          errors++;
        end else begin
          want = pending_fetches.pop_front();
          check_field("screen_column", want.column, got.column);
          check_field("tile_index", want.tile, got.tile);
          check_field("pixel_col", want.px, got.px);
          check_field("pixel_row", want.py, got.py);
          check_field("palette_bank", want.bank, got.bank);
          check_field("full_colour", want.full, got.full);
          check_field("layer_priority", want.prio, got.prio);
          check_field("fetch_base", want.base, got.base);
          check_field("run_end", want.last, got.last);
          fetches_checked++;
        end
      end
      if (quiet_cycles >= StallLimit) begin
        $display("%0t timeout: no transfer for %0d cycles, %0d fetches outstanding",
                 $time, StallLimit, pending_fetches.size());
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  initial begin
    rst_ni = 1'b0;
    sprite_ch.valid = 1'b0;
    sprite_ch.attr_word0 = '0;
    sprite_ch.attr_word1 = '0;
    sprite_ch.attr_word2 = '0;
    cfg_we = 1'b0;
    cfg_idx = CFG_CURRENT_LINE;
    cfg_wdata = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_values();
    test_shapes();
    test_attributes();
    test_random(8'd227, 1'b1, 17'h1FFFF, 50);
    test_random(8'd0, 1'b0, 17'h0, 50);
    steady = 1'b1;
    test_random(8'($urandom_range(0, 227)), 1'($urandom), 17'($urandom), 50);
    steady = 1'b0;
    test_output_hold();
    repeat (3) test_random(8'($urandom_range(0, 227)), 1'($urandom), 17'($urandom), 50);
    drain();
    repeat (20) @(posedge clk_i);

    $display("Sent %0d sprites, checked %0d fetch requests across %0d register settings.",
             sprites_sent, fetches_checked, settings_used);
    if (errors == 0 && pending_fetches.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d errors, %0d fetches never seen", errors, pending_fetches.size());
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
